### src/cpu_alu_with_flags_top_defines.svh
// Assertion macros used by the ALU block's top-level RTL file.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef CPU_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/cpu_alu_pkg.sv
// Types and operation codes for the 8-bit ALU with flag register.
// No dependencies; used by the interfaces, the core and the top level.
package cpu_alu_pkg;

  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_CP    = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_XOR   = 5'd5;
  localparam logic [4:0] CMD_OR    = 5'd6;
  localparam logic [4:0] CMD_INC   = 5'd7;
  localparam logic [4:0] CMD_DEC   = 5'd8;
  localparam logic [4:0] CMD_RL    = 5'd9;
  localparam logic [4:0] CMD_RLC   = 5'd10;
  localparam logic [4:0] CMD_RR    = 5'd11;
  localparam logic [4:0] CMD_RRC   = 5'd12;
  localparam logic [4:0] CMD_SLA   = 5'd13;
  localparam logic [4:0] CMD_SRA   = 5'd14;
  localparam logic [4:0] CMD_SRL   = 5'd15;
  localparam logic [4:0] CMD_SWAP  = 5'd16;
  localparam logic [4:0] CMD_BIT   = 5'd17;
  localparam logic [4:0] CMD_ADD16 = 5'd18;

  typedef struct packed {
    logic zero;
    logic subtract;
    logic half_carry;
    logic carry;
  } flags_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        set_zero;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
  } out_item_t;

endpackage

### src/cpu_alu_ifs.sv
// Valid/ready stream interfaces for the ALU operation and response channels.
// Depends on cpu_alu_pkg for the payload types.
interface cpu_alu_op_if import cpu_alu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpu_alu_rsp_if import cpu_alu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/cpu_alu_with_flags_top.sv
// Top level of the 8-bit ALU with kept flag register.
// Depends on cpu_alu_pkg, the stream interfaces, cpu_alu_core and the defines header.
//
// Usage:
//   Operations arrive on the "operation" channel and responses leave on the
//   "response" channel. Both are valid/ready streams; a transfer happens on a
//   rising clock edge where valid and ready are both high.
//   Each operation is captured in an input register. While it waits there,
//   the ALU core computes the result and new flags, which are loaded into the
//   response register and into the flag register together once the response
//   register is free. The response then stays valid until it is taken.
//   Throughput is one operation per cycle while the receiver keeps up: the
//   only dependency between items is the stored flag register, which is
//   written in the same cycle the result is produced, so the following item
//   already sees it.
//   When the receiver stalls, the response register holds its result and the
//   input register fills; operation.ready then drops until the response is
//   taken. No item is dropped or repeated.
//   Reset (rst, synchronous, active high) empties both registers and clears
//   all four flags.
`include "cpu_alu_with_flags_top_defines.svh"

module cpu_alu_with_flags_top import cpu_alu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cpu_alu_op_if.sink    operation,
  cpu_alu_rsp_if.source response
);

  logic        stage_valid;
  in_item_t    stage_item;
  logic        out_valid;
  out_item_t   out_item;
  flags_t      flag_bits;

  logic        advance;
  logic        out_free;
  logic [15:0] core_result;
  flags_t      core_flags;

  cpu_alu_core u_core (
    .item       (stage_item),
    .flags      (flag_bits),
    .result     (core_result),
    .flags_next (core_flags)
  );

  // The response register can load when it is empty or its content leaves now.
  assign out_free        = !out_valid || response.ready;
  assign advance         = stage_valid && out_free;
  assign operation.ready = !stage_valid || advance;

  assign response.valid  = out_valid;
  assign response.data   = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      flag_bits   <= '0;
    end else begin
      if (operation.ready) begin
        stage_valid <= operation.valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
      // Flags are committed in the same cycle as the result that carries them.
      if (advance) begin
        flag_bits <= core_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (operation.valid && operation.ready) begin
      stage_item <= operation.data;
    end
    if (advance) begin
      out_item <= '{result: core_result,
                    zero_flag: core_flags.zero,
                    subtract_flag: core_flags.subtract,
                    half_carry_flag: core_flags.half_carry,
                    carry_flag: core_flags.carry};
    end
  end

  // A waiting response always shows the flags that are stored.
  `ASSERT_IMPL(a_flags_match_out, clk, rst, out_valid,
    flag_bits == {out_item.zero_flag, out_item.subtract_flag,
                  out_item.half_carry_flag, out_item.carry_flag})
  // An empty input register never blocks the operation channel.
  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !stage_valid, operation.ready)
  // An accepted operation is held in the input register next cycle.
  `ASSERT_NEXT(a_accept_fills, clk, rst, operation.valid && operation.ready, stage_valid)
  // Moving an item forward always leaves a valid response behind.
  `ASSERT_NEXT(a_advance_outputs, clk, rst, advance, out_valid)

endmodule

### src/cpu_alu_core.sv
// Combinational datapath of the ALU: result value and new flags for one item.
// Depends on cpu_alu_pkg for codes and types.
module cpu_alu_core import cpu_alu_pkg::*; (
  input  in_item_t    item,
  input  flags_t      flags,
  output logic [15:0] result,
  output flags_t      flags_next
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [7:0]  diff8;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [7:0]  res8;

  assign a     = item.operand_a[7:0];
  assign b     = item.operand_b[7:0];
  // Plain add ignores the stored carry.
  assign cin   = (item.command == CMD_ADC) ? flags.carry : 1'b0;
  assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign diff8 = a - b;
  assign sum16 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign sum12 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

  always_comb begin
    res8       = 8'd0;
    result     = item.operand_a;
    flags_next = flags;
    case (item.command)
      CMD_ADD, CMD_ADC: begin
        res8 = sum8[7:0];
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0,
                       half_carry: sum4[4], carry: sum8[8]};
        result = {8'd0, res8};
      end
      CMD_SUB, CMD_CP: begin
        flags_next = '{zero: diff8 == 8'd0, subtract: 1'b1,
                       half_carry: a[3:0] < b[3:0], carry: a < b};
        if (item.command == CMD_SUB) begin
          result = {8'd0, diff8};
        end
      end
      CMD_AND: begin
        res8 = a & b;
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0, half_carry: 1'b1, carry: 1'b0};
        result = {8'd0, res8};
      end
      CMD_XOR, CMD_OR, CMD_SWAP: begin
        case (item.command)
          CMD_XOR: res8 = a ^ b;
          CMD_OR:  res8 = a | b;
          default: res8 = {a[3:0], a[7:4]};
        endcase
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0, half_carry: 1'b0, carry: 1'b0};
        result = {8'd0, res8};
      end
      CMD_INC: begin
        res8 = a + 8'd1;
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0,
                       half_carry: a[3:0] == 4'hF, carry: flags.carry};
        result = {8'd0, res8};
      end
      CMD_DEC: begin
        res8 = a - 8'd1;
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b1,
                       half_carry: a[3:0] == 4'h0, carry: flags.carry};
        result = {8'd0, res8};
      end
      CMD_RL, CMD_RLC, CMD_SLA: begin
        case (item.command)
          CMD_RL:  res8 = {a[6:0], flags.carry};
          CMD_RLC: res8 = {a[6:0], a[7]};
          default: res8 = {a[6:0], 1'b0};
        endcase
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
        result = {8'd0, res8};
      end
      CMD_RR, CMD_RRC, CMD_SRA, CMD_SRL: begin
        case (item.command)
          CMD_RR:  res8 = {flags.carry, a[7:1]};
          CMD_RRC: res8 = {a[0], a[7:1]};
          CMD_SRA: res8 = {a[7], a[7:1]};
          default: res8 = {1'b0, a[7:1]};
        endcase
        flags_next = '{zero: res8 == 8'd0, subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
        result = {8'd0, res8};
      end
      CMD_BIT: begin
        flags_next = '{zero: ~a[item.bit_index], subtract: 1'b0,
                       half_carry: 1'b1, carry: flags.carry};
      end
      CMD_ADD16: begin
        result = sum16[15:0];
        flags_next = '{zero: item.set_zero ? (sum16[15:0] == 16'd0) : flags.zero,
                       subtract: 1'b0, half_carry: sum12[12], carry: sum16[16]};
      end
      default: begin
        // Unassigned codes pass operand_a through and keep every flag.
        result     = item.operand_a;
        flags_next = flags;
      end
    endcase
  end

endmodule

### bench/cpu_alu_flags_checker.sv
// Checker for the 8-bit ALU: watches both streams, predicts every response.
// Depends on cpu_alu_pkg and the stream interfaces in cpu_alu_ifs.sv.
`timescale 1ns / 1ps

module cpu_alu_flags_checker import cpu_alu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cpu_alu_op_if  op,
  cpu_alu_rsp_if rsp,
  output int     fail_count,
  output int     pending
);

  flags_t    flag_state;
  out_item_t expected_rsp[$];
  int        err_total = 0;

  // Computes the response of one operation from the flags stored before it.
  function automatic out_item_t alu_expect(input in_item_t item, input flags_t fl);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] low13;
    logic        cin;
    logic        is8;
    logic [15:0] res;
    flags_t      f;
    out_item_t   o;
    a   = item.operand_a[7:0];
    b   = item.operand_b[7:0];
    r8  = '0;
    is8 = 1'b1;
    res = item.operand_a;
    f   = fl;
    case (item.command)
      CMD_ADD, CMD_ADC: begin
        cin  = (item.command == CMD_ADC) ? fl.carry : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        r8   = sum9[7:0];
        f    = {r8 == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      CMD_SUB, CMD_CP: begin
        r8 = a - b;
        f  = {r8 == 8'h00, 1'b1, a[3:0] < b[3:0], a < b};
        // Compare hands back the untouched 16-bit register.
        is8 = (item.command == CMD_SUB);
      end
      CMD_AND: begin
        r8 = a & b;
        f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      CMD_XOR: begin
        r8 = a ^ b;
        f  = {r8 == 8'h00, 3'b000};
      end
      CMD_OR: begin
        r8 = a | b;
        f  = {r8 == 8'h00, 3'b000};
      end
      CMD_INC: begin
        r8 = a + 8'd1;
        f  = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, fl.carry};
      end
      CMD_DEC: begin
        r8 = a - 8'd1;
        f  = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, fl.carry};
      end
      CMD_RL: begin
        r8 = {a[6:0], fl.carry};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      CMD_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      CMD_RR: begin
        r8 = {fl.carry, a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      CMD_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      CMD_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      CMD_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      CMD_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      CMD_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {r8 == 8'h00, 3'b000};
      end
      CMD_BIT: begin
        is8 = 1'b0;
        f   = {~a[item.bit_index], 1'b0, 1'b1, fl.carry};
      end
      CMD_ADD16: begin
        is8   = 1'b0;
        sum17 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
        low13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
        res   = sum17[15:0];
        f     = {item.set_zero ? (res == 16'h0000) : fl.zero, 1'b0, low13[12], sum17[16]};
      end
      default: begin
        // Unused codes pass the register through and keep every flag.
        is8 = 1'b0;
      end
    endcase
    if (is8) begin
      res = {8'h00, r8};
    end
    o.result          = res;
    o.zero_flag       = f.zero;
    o.subtract_flag   = f.subtract;
    o.half_carry_flag = f.half_carry;
    o.carry_flag      = f.carry;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst) begin
      flag_state <= '0;
      expected_rsp.delete();
    end else begin
      // Responses first, so one arriving on an empty queue is never masked.
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (expected_rsp.size() == 0) begin
          $error("response transfer with no operation outstanding: result 0x%0h", got.result);
          err_total++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("result", want.result, got.result);
          check_field("zero_flag", {15'd0, want.zero_flag}, {15'd0, got.zero_flag});
          check_field("subtract_flag", {15'd0, want.subtract_flag},
                      {15'd0, got.subtract_flag});
          check_field("half_carry_flag", {15'd0, want.half_carry_flag},
                      {15'd0, got.half_carry_flag});
          check_field("carry_flag", {15'd0, want.carry_flag}, {15'd0, got.carry_flag});
        end
      end
      if (op.valid && op.ready) begin
        want = alu_expect(op.data, flag_state);
        expected_rsp.push_back(want);
        flag_state <= {want.zero_flag, want.subtract_flag, want.half_carry_flag,
                       want.carry_flag};
      end
    end
    pending    <= expected_rsp.size();
    fail_count <= err_total;
  end

endmodule

### bench/cpu_alu_with_flags_top_tb.sv
// Top of the ALU testbench: clock, reset, stimulus, response back-pressure, verdict.
// Depends on cpu_alu_pkg, cpu_alu_ifs.sv, the block and cpu_alu_flags_checker.
`timescale 1ns / 1ps

module cpu_alu_with_flags_top_tb;
  import cpu_alu_pkg::*;

  // Size of the random part of the stimulus.
  localparam int RANDOM_OPS = 1450;
  // The receiver's long hold-off: when it starts, counted from the end of
  // reset, and how long it lasts. Long enough that the block's two registers
  // fill and the operation channel stalls while the sender keeps offering.
  localparam int HOLD_START = 400;
  localparam int HOLD_LEN   = 150;
  // Cycles allowed after the last response for anything stray to show up.
  localparam int DRAIN_CYCLES = 12;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  cpu_alu_op_if  op_ch ();
  cpu_alu_rsp_if rsp_ch ();

  cpu_alu_with_flags_top dut (
    .clk       (clk),
    .rst       (rst),
    .operation (op_ch),
    .response  (rsp_ch)
  );

  cpu_alu_flags_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .op         (op_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset is held at the start and never again.
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Generous fixed limit; a correct run ends far sooner.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_item_t make_op(input logic [4:0] cmd, input logic [15:0] a,
                                       input logic [15:0] b, input logic [2:0] bi,
                                       input logic sz);
    in_item_t item;
    item.command   = cmd;
    item.operand_a = a;
    item.operand_b = b;
    item.bit_index = bi;
    item.set_zero  = sz;
    return item;
  endfunction

  // Operand values lean toward the corners where carries and zero results
  // happen; the upper byte is random noise for most 8-bit picks.
  function automatic logic [15:0] pick_operand();
    logic [7:0] noise;
    noise = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {noise, 8'hFF};
      3: return {noise, 8'h00};
      4: return {noise, 8'h0F};
      5: return {noise, 8'h80};
      6: return {4'h0, 12'hFFF} | {noise[3:0], 12'h000};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_item_t rand_op();
    logic [4:0] cmd;
    // Mostly defined operations, with a sprinkle of unused codes.
    if ($urandom_range(0, 19) == 0) begin
      cmd = 5'($urandom_range(19, 31));
    end else begin
      cmd = 5'($urandom_range(0, 18));
    end
    return make_op(cmd, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)));
  endfunction

  // Offers one operation and holds it until the transfer. Valid is left high
  // so that a following item in the same burst goes out back to back.
  task automatic send_op(input in_item_t item);
    op_ch.valid <= 1'b1;
    op_ch.data  <= item;
    do @(posedge clk); while (!op_ch.ready);
  endtask

  // Lowers valid and waits until the checker holds no outstanding response.
  // The extra edge lets the count catch up with the last transfer.
  task automatic wait_drained();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sender: a directed opening, then random operations in bursts with gaps.
  initial begin : sender
    in_item_t directed[$];
    int       burst_left;
    int       gap;
    op_ch.valid = 1'b0;
    op_ch.data  = '0;
    burst_left  = 0;

    // Carry-producing add with garbage in the upper operand bytes.
    directed.push_back(make_op(CMD_ADD, 16'hABFF, 16'hCD01, 3'd0, 1'b0));
    // Add with carry: the carry left by the add above feeds the half-carry.
    directed.push_back(make_op(CMD_ADC, 16'h000F, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_ADC, 16'h00FF, 16'h00FF, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SUB, 16'h0010, 16'h0001, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SUB, 16'hFF00, 16'h0001, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_CP, 16'h1234, 16'h0034, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_AND, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_AND, 16'h00F0, 16'h000F, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_XOR, 16'h5AA5, 16'h00A5, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_OR, 16'hFF00, 16'hFF00, 3'd0, 1'b0));
    // Increment and decrement keep the stored carry: set it first.
    directed.push_back(make_op(CMD_SUB, 16'h0000, 16'h0001, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_INC, 16'h00FF, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_DEC, 16'h0000, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_DEC, 16'h0001, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_RL, 16'h0080, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_RLC, 16'h0080, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_RR, 16'h0001, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_RRC, 16'h0001, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SLA, 16'h00FF, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SRA, 16'h0080, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SRL, 16'h0001, 16'h0000, 3'd0, 1'b0));
    directed.push_back(make_op(CMD_SWAP, 16'h00F0, 16'h0000, 3'd0, 1'b0));
    // Bit test keeps the carry and returns the full 16-bit register.
    directed.push_back(make_op(CMD_BIT, 16'hFF7F, 16'h0000, 3'd7, 1'b0));
    directed.push_back(make_op(CMD_BIT, 16'h0001, 16'h0000, 3'd0, 1'b0));
    // 16-bit add: full overflow with zero update, then half-carry without.
    directed.push_back(make_op(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0, 1'b1));
    directed.push_back(make_op(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0, 1'b0));
    // Unused codes at both ends of the gap leave everything alone.
    directed.push_back(make_op(5'd19, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1));
    directed.push_back(make_op(5'd31, 16'h0000, 16'hFFFF, 3'd7, 1'b1));

    do @(posedge clk); while (rst);

    foreach (directed[i]) begin
      send_op(directed[i]);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // Once in the middle, the sender stops until every response is back.
      if (n == RANDOM_OPS / 2) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        if ($urandom_range(0, 9) == 0) begin
          gap = $urandom_range(15, 40);
        end else begin
          gap = $urandom_range(0, 5);
        end
        if (gap > 0) begin
          op_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_op(rand_op());
      burst_left--;
    end

    // Everything is sent: wait for the last response, then a short drain.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: ready follows a pattern whose mode is picked at random (always
  // ready, light stalls, heavy stalls, alternating), with one long hold-off
  // counted in this process's own cycles.
  initial begin : receiver
    int cycle;
    int mode;
    int mode_left;
    logic ready_next;
    rsp_ch.ready = 1'b0;
    cycle        = 0;
    mode         = 0;
    mode_left    = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      case (mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        2: ready_next = ($urandom_range(0, 9) < 4);
        default: ready_next = cycle[0];
      endcase
      if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN) begin
        ready_next = 1'b0;
      end
      rsp_ch.ready <= ready_next;
      mode_left--;
      cycle++;
      @(posedge clk);
    end
  end

endmodule
